// ===== src/assert_macros.svh =====
// assertion macros used by the checker file dmpd_checker.sv
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every edge outside reset
`define DMPD_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("dmpd assertion failed");

// same-cycle implication, checked outside reset
`define DMPD_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dmpd assertion failed");

// next-cycle implication, checked outside reset
`define DMPD_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dmpd assertion failed");

`endif

// ===== src/dmpd_pkg.sv =====
// types and constants for the dcc mobile packet dispatcher
// no dependencies; used by every module of the block
`default_nettype none

package dmpd_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_SHORT_ADDR   = 3'd0;
  localparam logic [2:0] REG_CONFIG_BITS  = 3'd1;
  localparam logic [2:0] REG_LONG_HIGH    = 3'd2;
  localparam logic [2:0] REG_LONG_LOW     = 3'd3;
  localparam logic [2:0] REG_CONSIST_ADDR = 3'd4;

  // register reset values
  localparam logic [7:0] RST_SHORT_ADDR = 8'd3;
  localparam logic [7:0] RST_LONG_HIGH  = 8'd192;

  // action codes
  localparam logic [3:0] ACT_NONE       = 4'd0;
  localparam logic [3:0] ACT_PROG_PAGE  = 4'd1;
  localparam logic [3:0] ACT_PROG_DIR   = 4'd2;
  localparam logic [3:0] ACT_SPEED128   = 4'd3;
  localparam logic [3:0] ACT_SPEED28    = 4'd4;
  localparam logic [3:0] ACT_FUNCTION   = 4'd5;
  localparam logic [3:0] ACT_CV_BYTE    = 4'd6;
  localparam logic [3:0] ACT_CV_BIT     = 4'd7;
  localparam logic [3:0] ACT_PAGE_RESET = 4'd8;
  localparam logic [3:0] ACT_PROG_TICK  = 4'd9;

  // direction codes
  localparam logic [1:0] DIR_UNSET = 2'd0;
  localparam logic [1:0] DIR_FWD   = 2'd1;
  localparam logic [1:0] DIR_BACK  = 2'd2;

  // function groups
  localparam logic [2:0] FG_F0_F4   = 3'd1;
  localparam logic [2:0] FG_F5_F8   = 3'd2;
  localparam logic [2:0] FG_F9_F12  = 3'd3;
  localparam logic [2:0] FG_F13_F20 = 3'd4;
  localparam logic [2:0] FG_F21_F28 = 3'd5;

  // operation codes of an input word
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // packet lengths of interest
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // instruction group codes, top three bits of the instruction byte
  localparam logic [2:0] INS_CONTROL   = 3'b000;
  localparam logic [2:0] INS_ADVANCED  = 3'b001;
  localparam logic [2:0] INS_SPEED_REV = 3'b010;
  localparam logic [2:0] INS_SPEED_FWD = 3'b011;
  localparam logic [2:0] INS_FG_ONE    = 3'b100;
  localparam logic [2:0] INS_FG_TWO    = 3'b101;
  localparam logic [2:0] INS_FEXP      = 3'b110;
  localparam logic [2:0] INS_CV        = 3'b111;

  // bit masks and match values
  localparam logic [7:0] SVC_MASK     = 8'h70;
  localparam logic [7:0] ADDR7_MASK   = 8'h7F;
  localparam logic [7:0] LONG_PREFIX  = 8'hC0;
  localparam logic [7:0] CONSIST_ESC  = 8'hE0;
  localparam logic [4:0] SPEED128_SUB = 5'h1F;
  localparam logic [7:0] FEXP_LOW     = 8'hDE;
  localparam logic [7:0] FEXP_HIGH    = 8'hDF;
  localparam logic [7:0] IDLE_BYTE    = 8'hFF;
  localparam logic [1:0] CV_HIGH_MASK = 2'h3;
  localparam logic [4:0] SVC_RELOAD   = 5'd30;

  // bit positions inside config_bits
  localparam int CFG_DIR_INV = 0;
  localparam int CFG_LONG    = 5;

  typedef struct packed {
    logic [7:0] short_addr;
    logic [7:0] config_bits;
    logic [7:0] long_high;
    logic [7:0] long_low;
    logic [7:0] consist_addr;
  } cfg_t;

  typedef struct packed {
    logic       operation;
    logic [2:0] packet_length;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [7:0] byte_four;
    logic [7:0] byte_five;
    logic       reverse_request;
  } item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [1:0]  direction;
    logic [7:0]  speed_code;
    logic [2:0]  function_group;
    logic [7:0]  function_bits;
    logic [10:0] cv_number;
    logic [7:0]  cv_data;
    logic        service_mode;
  } result_t;

  typedef struct packed {
    logic [4:0] svc_count;
    logic [7:0] consist;
    logic [1:0] last_dir;
  } state_t;

endpackage

`default_nettype wire

// ===== src/dmpd_cfg_regs.sv =====
// configuration register file of the packet dispatcher
// depends on dmpd_pkg for the register indexes and the cfg_t struct
`default_nettype none

module dmpd_cfg_regs (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_write_en,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [7:0]      cfg_data,
  output dmpd_pkg::cfg_t       cfg_o
);

  dmpd_pkg::cfg_t regs_r;

  // indexed write, writes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.short_addr   <= dmpd_pkg::RST_SHORT_ADDR;
      regs_r.config_bits  <= '0;
      regs_r.long_high    <= dmpd_pkg::RST_LONG_HIGH;
      regs_r.long_low     <= '0;
      regs_r.consist_addr <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        dmpd_pkg::REG_SHORT_ADDR:   regs_r.short_addr   <= cfg_data;
        dmpd_pkg::REG_CONFIG_BITS:  regs_r.config_bits  <= cfg_data;
        dmpd_pkg::REG_LONG_HIGH:    regs_r.long_high    <= cfg_data;
        dmpd_pkg::REG_LONG_LOW:     regs_r.long_low     <= cfg_data;
        dmpd_pkg::REG_CONSIST_ADDR: regs_r.consist_addr <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_o = regs_r;

endmodule

`default_nettype wire

// ===== src/dmpd_decode.sv =====
// packet decode: routing, address match and instruction decode of one word
// depends on dmpd_pkg; purely combinational, state update returned as next value
`default_nettype none

module dmpd_decode (
  input  wire dmpd_pkg::cfg_t    cfg_i,
  input  wire dmpd_pkg::item_t   item_i,
  input  wire dmpd_pkg::state_t  state_i,
  output dmpd_pkg::result_t result_o,
  output dmpd_pkg::state_t  state_nxt
);

  logic       svc_on;
  logic       svc_pkt;
  logic       reset_pkt;
  logic       idle_pkt;
  logic       latch_hit;
  logic [7:0] consist_now;
  logic       addr_ok;
  logic       long_sel;
  logic [7:0] ins;
  logic [7:0] arg1;
  logic [7:0] arg2;
  logic [2:0] len_plain;
  logic [2:0] len_adv;
  logic       len_plain_ok;
  logic       len_adv_ok;
  logic       cfg_long;
  logic       dir_inv;
  logic [10:0] cv_sum;

  // packet classes
  assign svc_on    = (state_i.svc_count != '0);
  assign svc_pkt   = svc_on && ((item_i.byte_zero & dmpd_pkg::SVC_MASK) == dmpd_pkg::SVC_MASK);
  assign reset_pkt = (item_i.byte_zero == '0) && (item_i.byte_one == '0)
                     && (item_i.byte_two == '0);
  assign idle_pkt  = (item_i.byte_zero == dmpd_pkg::IDLE_BYTE) && (item_i.byte_one == '0)
                     && (item_i.byte_two == dmpd_pkg::IDLE_BYTE);

  assign cfg_long = cfg_i.config_bits[dmpd_pkg::CFG_LONG];
  assign dir_inv  = cfg_i.config_bits[dmpd_pkg::CFG_DIR_INV] ^ item_i.reverse_request;

  // consist latch, applied before the address match
  assign latch_hit = (cfg_i.consist_addr != '0) && !item_i.byte_zero[7]
                     && ((item_i.byte_one & dmpd_pkg::CONSIST_ESC) != dmpd_pkg::CONSIST_ESC);
  assign consist_now = latch_hit ? cfg_i.consist_addr : state_i.consist;

  // address match: consist, short or long
  always_comb begin
    addr_ok  = 1'b0;
    long_sel = 1'b0;
    priority if (consist_now != '0) begin
      addr_ok = (item_i.byte_zero != '0)
                && (consist_now == (item_i.byte_zero & dmpd_pkg::ADDR7_MASK));
    end else if (!item_i.byte_zero[7] && !cfg_long) begin
      addr_ok = (item_i.byte_zero == cfg_i.short_addr);
    end else if (((item_i.byte_zero & dmpd_pkg::LONG_PREFIX) == dmpd_pkg::LONG_PREFIX)
                 && cfg_long) begin
      addr_ok  = (item_i.byte_zero == cfg_i.long_high) && (item_i.byte_one == cfg_i.long_low);
      long_sel = 1'b1;
    end else begin
      addr_ok = 1'b0;
    end
  end

  // instruction bytes follow the address
  assign ins  = long_sel ? item_i.byte_two   : item_i.byte_one;
  assign arg1 = long_sel ? item_i.byte_three : item_i.byte_two;
  assign arg2 = long_sel ? item_i.byte_four  : item_i.byte_three;

  // lengths count the address bytes, the instruction, its data and the checksum
  assign len_plain    = long_sel ? 3'd4 : 3'd3;
  assign len_adv      = long_sel ? 3'd5 : 3'd4;
  assign len_plain_ok = (item_i.packet_length == len_plain);
  assign len_adv_ok   = (item_i.packet_length == len_adv);

  assign cv_sum = {1'b0, ins[1:0] & dmpd_pkg::CV_HIGH_MASK, 8'h00} + {3'b000, arg1} + 11'd1;

  // routing and instruction decode
  always_comb begin
    result_o  = '0;
    state_nxt = state_i;
    priority if (item_i.operation == dmpd_pkg::OP_TICK) begin
      if (svc_on) begin
        state_nxt.svc_count = state_i.svc_count - 5'd1;
        result_o.action     = dmpd_pkg::ACT_PROG_TICK;
      end
    end else if (item_i.packet_length == dmpd_pkg::LEN_TWO) begin
      result_o.action = dmpd_pkg::ACT_NONE;
    end else if (svc_pkt) begin
      state_nxt.svc_count = dmpd_pkg::SVC_RELOAD;
      if (item_i.packet_length == dmpd_pkg::LEN_THREE) begin
        if (!idle_pkt) result_o.action = dmpd_pkg::ACT_PROG_PAGE;
      end else if (item_i.packet_length == dmpd_pkg::LEN_FOUR) begin
        result_o.action = dmpd_pkg::ACT_PROG_DIR;
      end
    end else if ((item_i.packet_length == dmpd_pkg::LEN_THREE) && reset_pkt) begin
      state_nxt.svc_count = dmpd_pkg::SVC_RELOAD;
      result_o.action     = dmpd_pkg::ACT_PAGE_RESET;
    end else if ((item_i.packet_length == dmpd_pkg::LEN_THREE) && idle_pkt) begin
      state_nxt.svc_count = '0;
    end else begin
      state_nxt.consist = consist_now;
      if (addr_ok) begin
        unique case (ins[7:5])
          dmpd_pkg::INS_ADVANCED: begin
            if (len_adv_ok && (ins[4:0] == dmpd_pkg::SPEED128_SUB)) begin
              state_nxt.last_dir  = (arg1[7] ^ dir_inv) ? dmpd_pkg::DIR_FWD : dmpd_pkg::DIR_BACK;
              result_o.speed_code = arg1 & dmpd_pkg::ADDR7_MASK;
              result_o.action     = dmpd_pkg::ACT_SPEED128;
            end
          end
          dmpd_pkg::INS_SPEED_REV, dmpd_pkg::INS_SPEED_FWD: begin
            if (len_plain_ok) begin
              state_nxt.last_dir  = (ins[5] ^ dir_inv) ? dmpd_pkg::DIR_FWD : dmpd_pkg::DIR_BACK;
              result_o.speed_code = ins;
              result_o.action     = dmpd_pkg::ACT_SPEED28;
            end
          end
          dmpd_pkg::INS_FG_ONE: begin
            if (len_plain_ok) begin
              result_o.function_group = dmpd_pkg::FG_F0_F4;
              result_o.function_bits  = ins;
              result_o.action         = dmpd_pkg::ACT_FUNCTION;
            end
          end
          dmpd_pkg::INS_FG_TWO: begin
            if (len_plain_ok) begin
              result_o.function_group = ins[4] ? dmpd_pkg::FG_F5_F8 : dmpd_pkg::FG_F9_F12;
              result_o.function_bits  = ins;
              result_o.action         = dmpd_pkg::ACT_FUNCTION;
            end
          end
          dmpd_pkg::INS_FEXP: begin
            if (ins == dmpd_pkg::FEXP_LOW || ins == dmpd_pkg::FEXP_HIGH) begin
              result_o.function_group = (ins == dmpd_pkg::FEXP_LOW) ? dmpd_pkg::FG_F13_F20
                                                                    : dmpd_pkg::FG_F21_F28;
              result_o.function_bits  = arg1;
              result_o.action         = dmpd_pkg::ACT_FUNCTION;
            end
          end
          dmpd_pkg::INS_CV: begin
            if (ins[3]) begin
              result_o.cv_number = cv_sum;
              result_o.cv_data   = arg2;
              result_o.action    = ins[2] ? dmpd_pkg::ACT_CV_BYTE : dmpd_pkg::ACT_CV_BIT;
            end
          end
          dmpd_pkg::INS_CONTROL: result_o.action = dmpd_pkg::ACT_NONE;
          default: result_o.action = dmpd_pkg::ACT_NONE;
        endcase
      end
    end
    result_o.direction    = state_nxt.last_dir;
    result_o.service_mode = (state_nxt.svc_count != '0);
  end

endmodule

`default_nettype wire

// ===== src/dcc_mobile_packet_dispatcher_top.sv =====
// top level of the dcc mobile packet dispatcher: input register, decode, result register
// depends on dmpd_pkg, dmpd_cfg_regs and dmpd_decode
`default_nettype none

// Takes one received DCC packet word (or a timer tick) per cycle and returns one
// result word per input word, in order. out_valid rises once the accepted word has
// passed the input register, where it is decoded against the current service
// countdown, consist latch and direction, and the decode is registered into the
// result stage. Throughput is one word per clock while the result stage is not
// stalled; the state update and the result are written in the same cycle, so the next
// word always decodes against the state left by the previous one. The block stalls
// only when both the input register and the result register hold a word and
// out_ready is low. Configuration writes take effect at the next edge and belong to
// idle periods.
module dcc_mobile_packet_dispatcher_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration port
  input  wire logic        cfg_write_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [2:0]  in_packet_length,
  input  wire logic [7:0]  in_byte_zero,
  input  wire logic [7:0]  in_byte_one,
  input  wire logic [7:0]  in_byte_two,
  input  wire logic [7:0]  in_byte_three,
  input  wire logic [7:0]  in_byte_four,
  input  wire logic [7:0]  in_byte_five,
  input  wire logic        in_reverse_request,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_action,
  output logic [1:0]       out_direction,
  output logic [7:0]       out_speed_code,
  output logic [2:0]       out_function_group,
  output logic [7:0]       out_function_bits,
  output logic [10:0]      out_cv_number,
  output logic [7:0]       out_cv_data,
  output logic             out_service_mode
);

  dmpd_pkg::cfg_t    cfg;
  dmpd_pkg::item_t   item_r;
  logic              item_valid_r;
  dmpd_pkg::state_t  state_r;
  dmpd_pkg::state_t  state_nxt;
  dmpd_pkg::result_t result_nxt;
  dmpd_pkg::result_t result_r;
  logic              out_valid_r;
  logic              advance;

  dmpd_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg_o        (cfg)
  );

  // handshake: the result stage moves when empty or drained
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !item_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.operation       <= in_operation;
      item_r.packet_length   <= in_packet_length;
      item_r.byte_zero       <= in_byte_zero;
      item_r.byte_one        <= in_byte_one;
      item_r.byte_two        <= in_byte_two;
      item_r.byte_three      <= in_byte_three;
      item_r.byte_four       <= in_byte_four;
      item_r.byte_five       <= in_byte_five;
      item_r.reverse_request <= in_reverse_request;
    end
  end

  dmpd_decode u_decode (
    .cfg_i     (cfg),
    .item_i    (item_r),
    .state_i   (state_r),
    .result_o  (result_nxt),
    .state_nxt (state_nxt)
  );

  // decoder state, updated as a word moves into the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance && item_valid_r) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = result_r.action;
  assign out_direction      = result_r.direction;
  assign out_speed_code     = result_r.speed_code;
  assign out_function_group = result_r.function_group;
  assign out_function_bits  = result_r.function_bits;
  assign out_cv_number      = result_r.cv_number;
  assign out_cv_data        = result_r.cv_data;
  assign out_service_mode   = result_r.service_mode;

endmodule

`default_nettype wire

// ===== src/dmpd_checker.sv =====
// port-level checker for the packet dispatcher, bound to the top level
// depends on dmpd_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module dmpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_action,
  input wire logic [1:0]  out_direction,
  input wire logic [7:0]  out_speed_code,
  input wire logic [2:0]  out_function_group,
  input wire logic [7:0]  out_function_bits,
  input wire logic [10:0] out_cv_number,
  input wire logic        out_service_mode
);

  // a stalled result word holds
  `DMPD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_action) && $stable(out_speed_code) && $stable(out_cv_number))

  // a speed command always leaves a set direction
  `DMPD_ASSERT_IMP(a_speed_dir, clk, rst_n, out_valid && (out_action == dmpd_pkg::ACT_SPEED128 || out_action == dmpd_pkg::ACT_SPEED28), out_direction != dmpd_pkg::DIR_UNSET)

  // a reset packet always enters service mode
  `DMPD_ASSERT_IMP(a_reset_svc, clk, rst_n, out_valid && out_action == dmpd_pkg::ACT_PAGE_RESET, out_service_mode)

  // function fields are zero unless the word is a function command
  `DMPD_ASSERT_IMP(a_fn_zero, clk, rst_n, out_valid && out_action != dmpd_pkg::ACT_FUNCTION, out_function_group == '0 && out_function_bits == '0)

endmodule

bind dcc_mobile_packet_dispatcher_top dmpd_checker u_dmpd_checker (.*);

`default_nettype wire
